// ----- hdl/rpa_pkg.sv -----
// shared types and constants of the reference-counted page allocator
// no dependencies; imported by rpa_ram users and the top level
package rpa_pkg;

  localparam int NUM_PAGES_DEF  = 32768;
  localparam int PAGE_SHIFT_DEF = 12;

  localparam int ADDR_W = 39;
  localparam int CNT_W  = 16;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 64;

  localparam logic [ADDR_W-1:0] RAM_BASE_RST   = 39'h0080000000;
  localparam logic [ADDR_W-1:0] KERNEL_END_RST = 39'h0080000000;

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_ADD_REF = 2'd2,
    ACT_RSVD    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_FREE   = 3'd1,
    ST_BAD_ADDR  = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_SATURATED = 3'd4
  } status_t;

  typedef enum logic {
    REG_RAM_BASE   = 1'b0,
    REG_KERNEL_END = 1'b1
  } reg_idx_t;

endpackage

// ----- hdl/rpa_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module rpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/refcounted_page_allocator.sv -----
// top level of the reference-counted page allocator: free list, counts, sequencer
// depends on rpa_pkg and rpa_ram
//
// channel  dir  handshake               payload
// in_      in   in_tvalid / in_tready   tuser: action; tdata: page_address
// out_     out  out_tvalid / out_tready tdata: result_address, status, page_freed, ref_count
// cfg_     in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// per item: accept issues the count and link reads, then the exec state does
// the update and write-back and loads the output register
// no clearing pass: pages not yet taken from the initial chain read count zero
// a held output stalls the update cycle; cfg_ready is always high
module refcounted_page_allocator #(
  parameter int NUM_PAGES  = rpa_pkg::NUM_PAGES_DEF,
  parameter int PAGE_SHIFT = rpa_pkg::PAGE_SHIFT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [1:0]                     in_tuser,   // action
  input  logic [rpa_pkg::IN_DATA_W-1:0]  in_tdata,   // page_address, zero pad
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // result_address, status, page_freed, ref_count, zero pad
  output logic [rpa_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [rpa_pkg::ADDR_W-1:0]     cfg_data
);

  import rpa_pkg::*;

  localparam int IDX_W = $clog2(NUM_PAGES);
  localparam int FC_W  = $clog2(NUM_PAGES + 1);
  localparam int FP_W  = ADDR_W + 1 - PAGE_SHIFT;
  localparam logic [ADDR_W:0] SPAN = (ADDR_W+1)'(longint'(NUM_PAGES) << PAGE_SHIFT);
  localparam logic [ADDR_W:0] PG_MASK = (ADDR_W+1)'((longint'(1) << PAGE_SHIFT) - 1);
  localparam logic [IDX_W-1:0] TOP_RST = IDX_W'(NUM_PAGES - 1);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t                 state_r, state_nxt;
  logic [ADDR_W-1:0]      base_r, kend_r;
  logic [FP_W-1:0]        first_pg_r;
  logic [IDX_W-1:0]       head_r, head_nxt;
  logic [FC_W-1:0]        fcnt_r, fcnt_nxt;
  logic [IDX_W-1:0]       top_r, top_nxt;
  logic                   live_r, live_nxt;
  action_t                act_r, act_nxt;
  logic [ADDR_W-1:0]      pa_r, pa_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic                   bad_r, bad_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0]  out_tdata_r, out_tdata_nxt;

  logic                   accept;
  logic [ADDR_W-1:0]      in_pa;
  logic [ADDR_W-1:0]      in_diff;
  logic                   in_bad;
  logic [ADDR_W:0]        fp_sum;

  logic                   refs_we, link_we;
  logic [IDX_W-1:0]       refs_waddr;
  logic [CNT_W-1:0]       refs_wdata;
  logic [CNT_W-1:0]       refs_rdata;
  logic [IDX_W-1:0]       link_rdata;

  logic [CNT_W-1:0]       cnt_cur, cnt_new;
  logic [IDX_W-1:0]       a_idx;
  logic [ADDR_W-1:0]      res_addr;
  status_t                res_status;
  logic                   res_freed;
  logic [CNT_W-1:0]       res_cnt;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign in_pa   = in_tdata[ADDR_W-1:0];
  assign in_diff = in_pa - base_r;
  assign in_bad  = (({1'b0, in_pa} & PG_MASK) != '0) || (in_pa < kend_r) ||
                   (in_pa < base_r) || ({1'b0, in_pa} >= ({1'b0, base_r} + SPAN));
  assign fp_sum  = {1'b0, kend_r} - {1'b0, base_r} + PG_MASK;

  rpa_ram #(.WIDTH(CNT_W), .DEPTH(NUM_PAGES)) u_refs (
    .clk   (clk),
    .we    (refs_we),
    .waddr (refs_waddr),
    .wdata (refs_wdata),
    .re    (accept),
    .raddr (in_diff[PAGE_SHIFT +: IDX_W]),
    .rdata (refs_rdata)
  );

  rpa_ram #(.WIDTH(IDX_W), .DEPTH(NUM_PAGES)) u_links (
    .clk   (clk),
    .we    (link_we),
    .waddr (idx_r),
    .wdata (head_r),
    .re    (accept),
    .raddr (head_r),
    .rdata (link_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    fcnt_nxt       = fcnt_r;
    top_nxt        = top_r;
    live_nxt       = live_r;
    act_nxt        = act_r;
    pa_nxt         = pa_r;
    idx_nxt        = idx_r;
    bad_nxt        = bad_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    refs_we        = 1'b0;
    link_we        = 1'b0;
    refs_waddr     = idx_r;
    refs_wdata     = '0;
    res_addr       = pa_r;
    res_status     = ST_OK;
    res_freed      = 1'b0;
    res_cnt        = '0;
    a_idx          = head_r;

    // pages still in the untaken chain were never written
    cnt_cur = (!live_r || idx_r > top_r) ? refs_rdata : '0;
    cnt_new = cnt_cur;

    if (accept) begin
      state_nxt = S_EXEC;
      act_nxt   = action_t'(in_tuser);
      pa_nxt    = in_pa;
      idx_nxt   = in_diff[PAGE_SHIFT +: IDX_W];
      bad_nxt   = in_bad;
    end

    if (state_r == S_EXEC && (!out_tvalid_r || out_tready)) begin
      case (act_r)
        ACT_ALLOC: begin
          if (fcnt_r != '0) begin
            a_idx    = head_r;
            head_nxt = link_rdata;
            fcnt_nxt = fcnt_r - FC_W'(1);
            refs_we  = 1'b1;
          end else if (live_r &&
                       {{(FP_W-IDX_W){1'b0}}, top_r} >= first_pg_r) begin
            a_idx = top_r;
            if (top_r == '0) begin
              live_nxt = 1'b0;
            end else begin
              top_nxt = top_r - IDX_W'(1);
            end
            refs_we = 1'b1;
          end
          refs_waddr = a_idx;
          refs_wdata = CNT_W'(1);
          if (refs_we) begin
            res_addr = base_r + ({{(ADDR_W-IDX_W){1'b0}}, a_idx} << PAGE_SHIFT);
            res_cnt  = CNT_W'(1);
          end else begin
            res_addr   = '0;
            res_status = ST_NO_FREE;
          end
        end
        ACT_RELEASE: begin
          if (bad_r) begin
            res_status = ST_BAD_ADDR;
          end else if (cnt_cur == '0) begin
            res_status = ST_UNDERFLOW;
          end else begin
            cnt_new    = cnt_cur - CNT_W'(1);
            refs_we    = 1'b1;
            refs_wdata = cnt_new;
            res_cnt    = cnt_new;
            if (cnt_new == '0) begin
              link_we   = 1'b1;
              head_nxt  = idx_r;
              fcnt_nxt  = fcnt_r + FC_W'(1);
              res_freed = 1'b1;
            end
          end
        end
        ACT_ADD_REF: begin
          if (bad_r) begin
            res_status = ST_BAD_ADDR;
          end else if (cnt_cur == '0) begin
            res_status = ST_UNDERFLOW;
          end else if (cnt_cur == '1) begin
            res_status = ST_SATURATED;
            res_cnt    = cnt_cur;
          end else begin
            cnt_new    = cnt_cur + CNT_W'(1);
            refs_we    = 1'b1;
            refs_wdata = cnt_new;
            res_cnt    = cnt_new;
          end
        end
        default: begin
          res_status = ST_BAD_ADDR;
        end
      endcase
      state_nxt      = S_IDLE;
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {{(OUT_DATA_W-ADDR_W-3-1-CNT_W){1'b0}},
                        res_cnt, res_freed, res_status, res_addr};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      base_r       <= RAM_BASE_RST;
      kend_r       <= KERNEL_END_RST;
      head_r       <= '0;
      fcnt_r       <= '0;
      top_r        <= TOP_RST;
      live_r       <= 1'b1;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      fcnt_r       <= fcnt_nxt;
      top_r        <= top_nxt;
      live_r       <= live_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_RAM_BASE: begin
            base_r <= cfg_data & ~PG_MASK[ADDR_W-1:0];
          end
          REG_KERNEL_END: begin
            kend_r <= cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r       <= act_nxt;
    pa_r        <= pa_nxt;
    idx_r       <= idx_nxt;
    bad_r       <= bad_nxt;
    out_tdata_r <= out_tdata_nxt;
    first_pg_r  <= (kend_r > base_r) ? fp_sum[ADDR_W:PAGE_SHIFT] : '0;
  end

endmodule
